>>> hdl/bcg_pkg.sv
package bcg_pkg;

   localparam int unsigned CountWidth = 11;
   localparam int unsigned PatternWidth = 8;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 16;

   localparam logic [CountWidth-1:0] CountMax = '1;
   localparam logic [CountWidth-1:0] LongPressReset = 11'd1000;
   localparam logic [CountWidth-1:0] SecondWindowReset = 11'd500;

   localparam logic [PatternWidth-1:0] PatternShortLong = 8'h1F;
   localparam logic [PatternWidth-1:0] PatternLong = 8'h0F;
   localparam logic [PatternWidth-1:0] PatternLongShort = 8'hFF;
   localparam logic [PatternWidth-1:0] PatternLongLong = 8'h00;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CsrLongPress = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrSecondWindow = 2'd1;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_HELD1  = 4'd1,
      PH_S_WAIT = 4'd2,
      PH_SS     = 4'd3,
      PH_SL     = 4'd4,
      PH_L_HELD = 4'd5,
      PH_L_WAIT = 4'd6,
      PH_LS     = 4'd7,
      PH_LL     = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      GEST_NONE        = 3'd0,
      GEST_SHORT       = 3'd1,
      GEST_SHORT_SHORT = 3'd2,
      GEST_SHORT_LONG  = 3'd3,
      GEST_LONG        = 3'd4,
      GEST_LONG_SHORT  = 3'd5,
      GEST_LONG_LONG   = 3'd6
   } gesture_type;

   typedef struct packed {
      phase_type                phase;
      logic [PatternWidth-1:0]  pattern;
      gesture_type              gesture;
   } result_type;

endpackage

>>> hdl/bcg_core.sv
module bcg_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step_en,
   input  logic                                    button_level,
   input  logic                                    csr_we,
   input  logic [bcg_pkg::CsrIndexWidth-1:0]       csr_index,
   input  logic [bcg_pkg::CountWidth-1:0]          csr_wdata,
   output bcg_pkg::result_type                     result
);

   logic [bcg_pkg::CountWidth-1:0]   long_ticks_ff;
   logic [bcg_pkg::CountWidth-1:0]   window_ff;
   bcg_pkg::phase_type               phase_ff;
   bcg_pkg::phase_type               phase_in;
   logic [bcg_pkg::CountWidth-1:0]   elapsed_ff;
   logic [bcg_pkg::CountWidth-1:0]   elapsed_in;
   logic [bcg_pkg::PatternWidth-1:0] pattern_ff;
   logic [bcg_pkg::PatternWidth-1:0] pattern_in;
   logic [bcg_pkg::CountWidth-1:0]   count_up;
   bcg_pkg::gesture_type             gesture;
   logic                             long_up;
   logic                             win_up;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff <= bcg_pkg::LongPressReset;
         window_ff     <= bcg_pkg::SecondWindowReset;
      end else if (csr_we) begin
         if (csr_index == bcg_pkg::CsrLongPress) begin
            long_ticks_ff <= csr_wdata;
         end
         if (csr_index == bcg_pkg::CsrSecondWindow) begin
            window_ff <= csr_wdata;
         end
      end
   end

   // The count advances before the timeouts are checked; a press or
   // release mark then clears it.
   always_comb begin
      count_up   = (elapsed_ff == bcg_pkg::CountMax) ? elapsed_ff : elapsed_ff + 1'b1;
      long_up    = count_up >= long_ticks_ff;
      win_up     = count_up >= window_ff;
      elapsed_in = count_up;
      phase_in   = phase_ff;
      pattern_in = pattern_ff;
      gesture    = bcg_pkg::GEST_NONE;
      unique case (phase_ff)
         bcg_pkg::PH_IDLE: begin
            if (button_level) begin
               elapsed_in = '0;
               phase_in   = bcg_pkg::PH_HELD1;
            end
         end
         bcg_pkg::PH_HELD1: begin
            if (long_up) begin
               phase_in = bcg_pkg::PH_L_HELD;
            end else if (!button_level) begin
               elapsed_in = '0;
               phase_in   = bcg_pkg::PH_S_WAIT;
            end
         end
         bcg_pkg::PH_S_WAIT: begin
            if (win_up) begin
               gesture    = bcg_pkg::GEST_SHORT;
               pattern_in = {pattern_ff[bcg_pkg::PatternWidth-2:0], 1'b1};
               phase_in   = bcg_pkg::PH_IDLE;
            end else if (button_level) begin
               elapsed_in = '0;
               phase_in   = bcg_pkg::PH_SS;
            end
         end
         bcg_pkg::PH_SS: begin
            if (long_up) begin
               phase_in = bcg_pkg::PH_SL;
            end else if (!button_level) begin
               gesture    = bcg_pkg::GEST_SHORT_SHORT;
               pattern_in = {1'b0, pattern_ff[bcg_pkg::PatternWidth-1:1]};
               phase_in   = bcg_pkg::PH_IDLE;
            end
         end
         bcg_pkg::PH_SL: begin
            if (!button_level) begin
               gesture    = bcg_pkg::GEST_SHORT_LONG;
               pattern_in = bcg_pkg::PatternShortLong;
               phase_in   = bcg_pkg::PH_IDLE;
            end
         end
         bcg_pkg::PH_L_HELD: begin
            if (!button_level) begin
               elapsed_in = '0;
               phase_in   = bcg_pkg::PH_L_WAIT;
            end
         end
         bcg_pkg::PH_L_WAIT: begin
            if (win_up) begin
               gesture    = bcg_pkg::GEST_LONG;
               pattern_in = bcg_pkg::PatternLong;
               phase_in   = bcg_pkg::PH_IDLE;
            end else if (button_level) begin
               elapsed_in = '0;
               phase_in   = bcg_pkg::PH_LS;
            end
         end
         bcg_pkg::PH_LS: begin
            if (long_up) begin
               phase_in = bcg_pkg::PH_LL;
            end else if (!button_level) begin
               gesture    = bcg_pkg::GEST_LONG_SHORT;
               pattern_in = bcg_pkg::PatternLongShort;
               phase_in   = bcg_pkg::PH_IDLE;
            end
         end
         bcg_pkg::PH_LL: begin
            if (!button_level) begin
               gesture    = bcg_pkg::GEST_LONG_LONG;
               pattern_in = bcg_pkg::PatternLongLong;
               phase_in   = bcg_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = bcg_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= bcg_pkg::PH_IDLE;
         elapsed_ff <= '0;
         pattern_ff <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         pattern_ff <= pattern_in;
      end
   end

   assign result.phase   = phase_in;
   assign result.pattern = pattern_in;
   assign result.gesture = gesture;

`ifndef SYNTHESIS
   a_gesture_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (step_en && gesture != bcg_pkg::GEST_NONE) |-> (phase_in == bcg_pkg::PH_IDLE))
      else $error("gesture reported without return to idle");

   a_press_mark: assert property (@(posedge clock) disable iff (reset)
      (step_en && phase_ff == bcg_pkg::PH_IDLE && button_level)
      |=> (elapsed_ff == '0 && phase_ff == bcg_pkg::PH_HELD1))
      else $error("press from idle did not clear the count");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> ($stable(phase_ff) && $stable(elapsed_ff) && $stable(pattern_ff)))
      else $error("classifier state moved without an item");
`endif

endmodule

>>> hdl/bcg_out_stage.sv
module bcg_out_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  bcg_pkg::result_type                   result,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [bcg_pkg::RspDataWidth-1:0]      rsp_tdata,
   output logic                                  can_load
);

   logic                rsp_valid_ff;
   bcg_pkg::result_type rsp_data_ff;

   // A new item may enter while the held one leaves in the same cycle.
   assign can_load = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bcg_pkg::RspDataWidth - $bits(bcg_pkg::result_type)){1'b0}},
                        rsp_data_ff};

`ifndef SYNTHESIS
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded item not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !load)
      else $error("held item overwritten");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tready && !load) |=> !rsp_valid_ff)
      else $error("taken item still presented");
`endif

endmodule

>>> hdl/button_click_gesture_classifier.sv
// Button gesture classifier: takes one button sample per tick on req_ and returns one
// item per sample on rsp_ holding the recognized gesture code (0 none, 1 short,
// 2 short-short, 3 short-long, 4 long, 5 long-short, 6 long-long), the kept LED pattern
// and the classifier phase after that sample. The phase update sits between the input
// handshake and a single output register, so a sample is accepted in every cycle while
// the output side keeps taking results; a stalled result holds the input back. The
// press length and second-click window thresholds are written on csr_ (index 0 and 1,
// 11 bits each); the user must write them while no item is in flight, unchecked by the block.
module button_click_gesture_classifier (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bcg_pkg::ReqDataWidth-1:0]      req_tdata,   // [0] button_level
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] gesture_code, [10:3] led_pattern, [14:11] phase_now
   output logic [bcg_pkg::RspDataWidth-1:0]      rsp_tdata,
   input  logic                                  csr_we,
   input  logic [bcg_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [bcg_pkg::CountWidth-1:0]        csr_wdata
);

   logic                step_en;
   logic                can_load;
   bcg_pkg::result_type result;

   assign req_tready = can_load;
   assign step_en    = req_tvalid && can_load;

   bcg_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .button_level (req_tdata[0]),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .result       (result)
   );

   bcg_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step_en),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .can_load   (can_load)
   );

endmodule
